[hdl/ell2c_pkg.sv]
// ----------------------------------------------------------------------------
// ell2c_pkg: shared types and constants
// CORDIC tables, fixed-point constants and the cell payload type.
// ----------------------------------------------------------------------------
package ell2c_pkg;

	localparam int CORDIC_STAGES_DEF   = 16;
	localparam int COORD_FRAC_BITS_DEF = 4;
	localparam int ATAN_ENTRIES        = 24;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
	localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [34:0] z;
		logic               flip;
		logic [14:0]        a;
		logic [14:0]        b;
		logic [15:0]        cx;
		logic [15:0]        cy;
	} cordic_t;

	function automatic logic [30:0] atan_q30(input int i);
		logic [30:0] r;
		case (i)
			0:  r = 31'h3243F6A8;
			1:  r = 31'h1DAC6705;
			2:  r = 31'h0FADBAFC;
			3:  r = 31'h07F56EA6;
			4:  r = 31'h03FEAB76;
			5:  r = 31'h01FFD55B;
			6:  r = 31'h00FFFAAA;
			7:  r = 31'h007FFF55;
			8:  r = 31'h003FFFEA;
			9:  r = 31'h001FFFFD;
			10: r = 31'h000FFFFF;
			11: r = 31'h0007FFFF;
			12: r = 31'h0003FFFF;
			13: r = 31'h0001FFFF;
			14: r = 31'h0000FFFF;
			15: r = 31'h00007FFF;
			16: r = 31'h00003FFF;
			17: r = 31'h00001FFF;
			18: r = 31'h00000FFF;
			19: r = 31'h000007FF;
			20: r = 31'h000003FF;
			21: r = 31'h000001FF;
			22: r = 31'h000000FF;
			23: r = 31'h0000007F;
			default: r = 31'h0;
		endcase
		return r;
	endfunction

endpackage

[hdl/ell2c_if.sv]
// ----------------------------------------------------------------------------
// ell2c_if: request and result channels
// Valid/ready channels carrying one ellipse request and one conic result.
// ----------------------------------------------------------------------------
interface ell2c_in_if;
	logic               valid;
	logic               ready;
	logic [14:0]        semi_major;
	logic [14:0]        semi_minor;
	logic [15:0]        centre_x;
	logic [15:0]        centre_y;
	logic signed [15:0] angle;
	modport source(output valid, semi_major, semi_minor, centre_x, centre_y, angle,
		input ready);
	modport sink(input valid, semi_major, semi_minor, centre_x, centre_y, angle,
		output ready);
endinterface

interface ell2c_out_if;
	logic               valid;
	logic               ready;
	logic [29:0]        coef_xx;
	logic signed [29:0] coef_xy_half;
	logic [29:0]        coef_yy;
	logic signed [43:0] coef_x_half;
	logic signed [43:0] coef_y_half;
	logic signed [55:0] coef_const;
	modport source(output valid, coef_xx, coef_xy_half, coef_yy, coef_x_half,
		coef_y_half, coef_const, input ready);
	modport sink(input valid, coef_xx, coef_xy_half, coef_yy, coef_x_half,
		coef_y_half, coef_const, output ready);
endinterface

[hdl/ell2c_cordic_cell.sv]
// ----------------------------------------------------------------------------
// ell2c_cordic_cell: one CORDIC rotation cell
// Rotates by +/- atan(2^-SHIFT) and hands the vector to the next cell.
// ----------------------------------------------------------------------------
module ell2c_cordic_cell #(
	parameter int SHIFT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ell2c_pkg::cordic_t in_data,
	output logic              in_ready,
	output logic              out_valid,
	output ell2c_pkg::cordic_t out_data,
	input  logic              out_ready
);
	localparam logic signed [34:0] ATAN = 35'(ell2c_pkg::atan_q30(SHIFT));

	logic               valid_q;
	ell2c_pkg::cordic_t data_s1;
	ell2c_pkg::cordic_t nxt;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		nxt = in_data;
		if (!in_data.z[34]) begin
			nxt.x = in_data.x - (in_data.y >>> SHIFT);
			nxt.y = in_data.y + (in_data.x >>> SHIFT);
			nxt.z = in_data.z - ATAN;
		end else begin
			nxt.x = in_data.x + (in_data.y >>> SHIFT);
			nxt.y = in_data.y - (in_data.x >>> SHIFT);
			nxt.z = in_data.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_s1;
endmodule

[hdl/ell2c_conic.sv]
// ----------------------------------------------------------------------------
// ell2c_conic: conic coefficient pipeline
// Rounds sine/cosine and forms A, B/2, C, D/2, E/2 and F over nine stages.
// ----------------------------------------------------------------------------
module ell2c_conic #(
	parameter int COORD_FRAC_BITS = ell2c_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  ell2c_pkg::cordic_t in_data,
	output logic               in_ready,
	ell2c_out_if.source        conic
);
	localparam int NST = 9;
	localparam int F   = COORD_FRAC_BITS;
	localparam int SH  = 2 * F + 24;
	localparam int ABF = 4 * F;
	localparam int ABDN = (ABF >= 8) ? ABF - 8 : 0;
	localparam int ABUP = (ABF < 8) ? 8 - ABF : 0;
	localparam logic [63:0] HALF_SH = (64'd1 << SH) >> 1;
	localparam logic signed [63:0] HALF_SH_S = $signed(HALF_SH);
	localparam logic signed [63:0] HALF_AB = $signed((64'd1 << ABDN) >> 1);
	localparam logic signed [63:0] HALF_F = $signed((64'd1 << F) >> 1);
	localparam logic signed [63:0] AB_LIM = 64'sh4000000000000000;
	localparam logic signed [63:0] AB_UP_LIM = AB_LIM >>> ABUP;
	localparam logic [63:0] CAP30 = 64'h3FFFFFFF;
	localparam logic signed [63:0] MAX30 = 64'sd536870911;
	localparam logic signed [63:0] MIN30 = -64'sd536870912;
	localparam logic signed [63:0] MAX44 = 64'sd8796093022207;
	localparam logic signed [63:0] MIN44 = -64'sd8796093022208;
	localparam logic signed [63:0] MAX56 = 64'sd36028797018963967;
	localparam logic signed [63:0] MIN56 = -64'sd36028797018963968;

	logic [NST-1:0] vq;
	logic [NST:0]   en;

	always_comb begin
		en[NST] = conic.ready;
		for (int k = NST - 1; k >= 0; k--) begin
			en[k] = !vq[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vq <= '0;
		end else begin
			if (en[0]) begin
				vq[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					vq[k] <= vq[k-1];
				end
			end
		end
	end

	// stage 0: round cos/sin to Q16, clamp to unit, undo the half-turn fold
	logic signed [19:0] xr, yr;
	logic signed [17:0] xc, yc;
	logic signed [17:0] c_s0, s_s0;
	logic [14:0] a_s0, b_s0;
	logic [15:0] cx_s0, cy_s0;

	always_comb begin
		xr = 20'((in_data.x + 34'sd8192) >>> 14);
		yr = 20'((in_data.y + 34'sd8192) >>> 14);
		xc = (xr > 20'sd65536) ? 18'sd65536 : ((xr < -20'sd65536) ? -18'sd65536 : 18'(xr));
		yc = (yr > 20'sd65536) ? 18'sd65536 : ((yr < -20'sd65536) ? -18'sd65536 : 18'(yr));
	end

	always_ff @(posedge clk) begin
		if (en[0] && in_valid) begin
			c_s0  <= in_data.flip ? -xc : xc;
			s_s0  <= in_data.flip ? -yc : yc;
			a_s0  <= in_data.a;
			b_s0  <= in_data.b;
			cx_s0 <= in_data.cx;
			cy_s0 <= in_data.cy;
		end
	end

	// stage 1: squares and the sine-cosine product
	logic [29:0] a2_s1, b2_s1;
	logic [32:0] ss_s1, cc_s1;
	logic signed [33:0] sc_s1;
	logic [15:0] cx_s1, cy_s1;
	logic signed [35:0] ssq, ccq, scq;

	always_comb begin
		ssq = s_s0 * s_s0;
		ccq = c_s0 * c_s0;
		scq = s_s0 * c_s0;
	end

	always_ff @(posedge clk) begin
		if (en[1] && vq[0]) begin
			a2_s1 <= a_s0 * a_s0;
			b2_s1 <= b_s0 * b_s0;
			ss_s1 <= ssq[32:0];
			cc_s1 <= ccq[32:0];
			sc_s1 <= 34'(scq);
			cx_s1 <= cx_s0;
			cy_s1 <= cy_s0;
		end
	end

	// stage 2: length-squared times trig products
	logic [62:0] pas_s2, pbc_s2, pac_s2, pbs_s2;
	logic signed [30:0] d_s2;
	logic signed [33:0] sc_s2;
	logic [29:0] a2_s2, b2_s2;
	logic [15:0] cx_s2, cy_s2;

	always_ff @(posedge clk) begin
		if (en[2] && vq[1]) begin
			pas_s2 <= 63'(a2_s1) * 63'(ss_s1);
			pbc_s2 <= 63'(b2_s1) * 63'(cc_s1);
			pac_s2 <= 63'(a2_s1) * 63'(cc_s1);
			pbs_s2 <= 63'(b2_s1) * 63'(ss_s1);
			d_s2   <= $signed({1'b0, b2_s1}) - $signed({1'b0, a2_s1});
			sc_s2  <= sc_s1;
			a2_s2  <= a2_s1;
			b2_s2  <= b2_s1;
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
		end
	end

	// stage 3: sums and cross products
	logic [63:0] ua_s3, uc_s3;
	logic signed [63:0] hp_s3;
	logic [59:0] ab_s3;
	logic [15:0] cx_s3, cy_s3;
	logic signed [64:0] hpq;

	assign hpq = d_s2 * sc_s2;

	always_ff @(posedge clk) begin
		if (en[3] && vq[2]) begin
			ua_s3 <= 64'(pas_s2) + 64'(pbc_s2);
			uc_s3 <= 64'(pac_s2) + 64'(pbs_s2);
			hp_s3 <= 64'(hpq);
			ab_s3 <= a2_s2 * b2_s2;
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
		end
	end

	// stage 4: round to Q8 and saturate
	logic [63:0] uar, ucr;
	logic signed [63:0] hr, abw, abr;
	logic [29:0] ua_s4, uc_s4;
	logic signed [29:0] hxy_s4;
	logic signed [63:0] abr_s4;
	logic [15:0] cx_s4, cy_s4;

	always_comb begin
		uar = (ua_s3 + HALF_SH) >> SH;
		ucr = (uc_s3 + HALF_SH) >> SH;
		hr  = (hp_s3 + HALF_SH_S) >>> SH;
		abw = $signed(64'(ab_s3));
		if (ABF >= 8) begin
			abr = (abw + HALF_AB) >>> ABDN;
		end else begin
			abr = (abw > AB_UP_LIM) ? AB_LIM : (abw <<< ABUP);
		end
	end

	always_ff @(posedge clk) begin
		if (en[4] && vq[3]) begin
			ua_s4  <= (uar > CAP30) ? 30'h3FFFFFFF : uar[29:0];
			uc_s4  <= (ucr > CAP30) ? 30'h3FFFFFFF : ucr[29:0];
			hxy_s4 <= (hr > MAX30) ? 30'(MAX30) : ((hr < MIN30) ? 30'(MIN30) : 30'(hr));
			abr_s4 <= abr;
			cx_s4  <= cx_s3;
			cy_s4  <= cy_s3;
		end
	end

	// stage 5: quadratic terms times centre
	logic [45:0] max_s5, mcy_s5;
	logic signed [46:0] mhy_s5, mhx_s5;
	logic [29:0] ua_s5, uc_s5;
	logic signed [29:0] hxy_s5;
	logic signed [63:0] abr_s5;
	logic [15:0] cx_s5, cy_s5;

	always_ff @(posedge clk) begin
		if (en[5] && vq[4]) begin
			max_s5 <= ua_s4 * cx_s4;
			mcy_s5 <= uc_s4 * cy_s4;
			mhy_s5 <= 47'(hxy_s4) * 47'($signed({1'b0, cy_s4}));
			mhx_s5 <= 47'(hxy_s4) * 47'($signed({1'b0, cx_s4}));
			ua_s5  <= ua_s4;
			uc_s5  <= uc_s4;
			hxy_s5 <= hxy_s4;
			abr_s5 <= abr_s4;
			cx_s5  <= cx_s4;
			cy_s5  <= cy_s4;
		end
	end

	// stage 6: D/2 and E/2
	logic signed [63:0] dsum, esum, dr, er;
	logic signed [43:0] dh_s6, eh_s6;
	logic [29:0] ua_s6, uc_s6;
	logic signed [29:0] hxy_s6;
	logic signed [63:0] abr_s6;
	logic [15:0] cx_s6, cy_s6;

	always_comb begin
		dsum = -$signed(64'(max_s5)) - 64'(mhy_s5);
		esum = -64'(mhx_s5) - $signed(64'(mcy_s5));
		dr   = (dsum + HALF_F) >>> F;
		er   = (esum + HALF_F) >>> F;
	end

	always_ff @(posedge clk) begin
		if (en[6] && vq[5]) begin
			dh_s6  <= (dr > MAX44) ? 44'(MAX44) : ((dr < MIN44) ? 44'(MIN44) : 44'(dr));
			eh_s6  <= (er > MAX44) ? 44'(MAX44) : ((er < MIN44) ? 44'(MIN44) : 44'(er));
			ua_s6  <= ua_s5;
			uc_s6  <= uc_s5;
			hxy_s6 <= hxy_s5;
			abr_s6 <= abr_s5;
			cx_s6  <= cx_s5;
			cy_s6  <= cy_s5;
		end
	end

	// stage 7: linear terms times centre
	logic signed [60:0] mdx_s7, mey_s7;
	logic signed [43:0] dh_s7, eh_s7;
	logic [29:0] ua_s7, uc_s7;
	logic signed [29:0] hxy_s7;
	logic signed [63:0] abr_s7;

	always_ff @(posedge clk) begin
		if (en[7] && vq[6]) begin
			mdx_s7 <= dh_s6 * $signed({1'b0, cx_s6});
			mey_s7 <= eh_s6 * $signed({1'b0, cy_s6});
			dh_s7  <= dh_s6;
			eh_s7  <= eh_s6;
			ua_s7  <= ua_s6;
			uc_s7  <= uc_s6;
			hxy_s7 <= hxy_s6;
			abr_s7 <= abr_s6;
		end
	end

	// stage 8: F and the output register
	logic signed [63:0] fsum, fr, fv;
	logic signed [55:0] f_s8;
	logic signed [43:0] dh_s8, eh_s8;
	logic [29:0] ua_s8, uc_s8;
	logic signed [29:0] hxy_s8;

	always_comb begin
		fsum = -(64'(mdx_s7) + 64'(mey_s7));
		fr   = (fsum + HALF_F) >>> F;
		fv   = fr - abr_s7;
	end

	always_ff @(posedge clk) begin
		if (en[8] && vq[7]) begin
			f_s8   <= (fv > MAX56) ? 56'(MAX56) : ((fv < MIN56) ? 56'(MIN56) : 56'(fv));
			dh_s8  <= dh_s7;
			eh_s8  <= eh_s7;
			ua_s8  <= ua_s7;
			uc_s8  <= uc_s7;
			hxy_s8 <= hxy_s7;
		end
	end

	assign conic.valid        = vq[NST-1];
	assign conic.coef_xx      = ua_s8;
	assign conic.coef_xy_half = hxy_s8;
	assign conic.coef_yy      = uc_s8;
	assign conic.coef_x_half  = dh_s8;
	assign conic.coef_y_half  = eh_s8;
	assign conic.coef_const   = f_s8;
endmodule

[hdl/ellipse_parameters_to_conic_top.sv]
// A request passes the fold register, the CORDIC cells and the conic pipeline stages.
// Throughput: one request per cycle unless stalled; each pipeline stage holds its
// own valid bit and fills bubbles, so a stalled result holds the stages behind it
// only once every stage between them is full.
// Each CORDIC cell performs one rotation per cycle unless stalled.
// Reset clears all valid bits; the pipeline is empty after reset.
// ----------------------------------------------------------------------------
// ellipse_parameters_to_conic_top: ellipse to conic matrix converter
// Angle fold, chain of CORDIC cells, then the conic coefficient pipeline.
// ----------------------------------------------------------------------------
module ellipse_parameters_to_conic_top #(
	parameter int CORDIC_STAGES   = ell2c_pkg::CORDIC_STAGES_DEF,
	parameter int COORD_FRAC_BITS = ell2c_pkg::COORD_FRAC_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	ell2c_in_if.sink    ellipse,
	ell2c_out_if.source conic
);
	ell2c_pkg::cordic_t cd  [CORDIC_STAGES+1];
	logic [CORDIC_STAGES:0] vld;
	logic [CORDIC_STAGES:0] rdy;

	logic               v0_q;
	ell2c_pkg::cordic_t d0_s1;
	ell2c_pkg::cordic_t fold;
	logic signed [34:0] zin;

	// bring the angle within a quarter turn; sine and cosine flip later
	always_comb begin
		zin       = 35'(ellipse.angle) <<< 17;
		fold.x    = ell2c_pkg::CORDIC_GAIN;
		fold.y    = '0;
		fold.a    = ellipse.semi_major;
		fold.b    = ellipse.semi_minor;
		fold.cx   = ellipse.centre_x;
		fold.cy   = ellipse.centre_y;
		fold.z    = zin;
		fold.flip = 1'b0;
		if (zin > ell2c_pkg::HALF_PI_Q30) begin
			fold.z    = zin - ell2c_pkg::PI_Q30;
			fold.flip = 1'b1;
		end else if (zin < -ell2c_pkg::HALF_PI_Q30) begin
			fold.z    = zin + ell2c_pkg::PI_Q30;
			fold.flip = 1'b1;
		end
	end

	assign ellipse.ready = !v0_q || rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
		end else if (ellipse.ready) begin
			v0_q <= ellipse.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ellipse.ready && ellipse.valid) begin
			d0_s1 <= fold;
		end
	end

	assign cd[0]  = d0_s1;
	assign vld[0] = v0_q;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		ell2c_cordic_cell #(.SHIFT(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[i]),
			.in_data   (cd[i]),
			.in_ready  (rdy[i]),
			.out_valid (vld[i+1]),
			.out_data  (cd[i+1]),
			.out_ready (rdy[i+1])
		);
	end

	ell2c_conic #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_conic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld[CORDIC_STAGES]),
		.in_data  (cd[CORDIC_STAGES]),
		.in_ready (rdy[CORDIC_STAGES]),
		.conic    (conic)
	);
endmodule

[dv/ellipse_parameters_to_conic_top_tb.sv]
// ----------------------------------------------------------------------------
// ellipse_parameters_to_conic_top_tb: self-checking bench for the conic converter
// Drives ellipse requests in random bursts, predicts the six conic entries with
// a CORDIC-based fixed-point model and checks each result in order.
// ----------------------------------------------------------------------------
module ellipse_parameters_to_conic_top_tb;

	localparam int STAGES    = ell2c_pkg::CORDIC_STAGES_DEF;
	localparam int FRAC      = ell2c_pkg::COORD_FRAC_BITS_DEF;
	localparam int LATENCY   = STAGES + 10;
	localparam int N_RANDOM  = 1300;
	localparam int MAX_CYCLES = 200000;

	typedef struct packed {
		logic [14:0]        semi_major;
		logic [14:0]        semi_minor;
		logic [15:0]        centre_x;
		logic [15:0]        centre_y;
		logic signed [15:0] angle;
	} ellipse_t;

	typedef struct packed {
		logic [29:0]        xx;
		logic signed [29:0] xy_half;
		logic [29:0]        yy;
		logic signed [43:0] x_half;
		logic signed [43:0] y_half;
		logic signed [55:0] cst;
	} conic_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	ell2c_in_if  ellipse_ch();
	ell2c_out_if conic_ch();

	ellipse_parameters_to_conic_top DUT (
		.clk(clk), .arst_n(arst_n), .ellipse(ellipse_ch.sink), .conic(conic_ch.source)
	);

	always #5 clk = ~clk;

	ellipse_t pending_q[$];
	conic_t   coef_expect_q[$];
	int       n_fail = 0;
	int       cycle_cnt = 0;
	bit       hold_send = 1'b0;
	bit       stim_done = 1'b0;

	function automatic longint asr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint asr_round(longint v, int s);
		if (s == 0)
			return v;
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint sat_signed(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) << (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic longint unit_clamp(longint v);
		return v > 65536 ? 65536 : (v < -65536 ? -65536 : v);
	endfunction

	function automatic conic_t conic_of(ellipse_t e);
		conic_t r;
		longint z, x, y, nx, c, s, a, b, cx, cy, a2, b2, hxy, dh, eh, f, ab;
		longint unsigned ua, uc, cap;
		bit flip;
		int sh;
		sh = 2 * FRAC + 24;
		cap = (64'd1 << 30) - 1;
		z = longint'(e.angle) * 131072;
		x = ell2c_pkg::CORDIC_GAIN;
		y = 0;
		flip = 1'b0;
		if (z > ell2c_pkg::HALF_PI_Q30) begin
			z -= ell2c_pkg::PI_Q30;
			flip = 1'b1;
		end else if (z < -longint'(ell2c_pkg::HALF_PI_Q30)) begin
			z += ell2c_pkg::PI_Q30;
			flip = 1'b1;
		end
		for (int i = 0; i < STAGES && i < ell2c_pkg::ATAN_ENTRIES; i++) begin
			if (z >= 0) begin
				nx = x - asr_floor(y, i);
				y = y + asr_floor(x, i);
				z -= longint'(ell2c_pkg::atan_q30(i));
			end else begin
				nx = x + asr_floor(y, i);
				y = y - asr_floor(x, i);
				z += longint'(ell2c_pkg::atan_q30(i));
			end
			x = nx;
		end
		c = unit_clamp(asr_round(x, 14));
		s = unit_clamp(asr_round(y, 14));
		if (flip) begin
			c = -c;
			s = -s;
		end
		a = e.semi_major;
		b = e.semi_minor;
		cx = e.centre_x;
		cy = e.centre_y;
		a2 = a * a;
		b2 = b * b;
		ua = longint'(a2) * (s * s) + longint'(b2) * (c * c);
		uc = longint'(a2) * (c * c) + longint'(b2) * (s * s);
		ua = (ua + (64'd1 << (sh - 1))) >> sh;
		uc = (uc + (64'd1 << (sh - 1))) >> sh;
		if (ua > cap) ua = cap;
		if (uc > cap) uc = cap;
		hxy = sat_signed(asr_round((b2 - a2) * (s * c), sh), 30);
		dh = sat_signed(asr_round(-(longint'(ua) * cx) - hxy * cy, FRAC), 44);
		eh = sat_signed(asr_round(-(hxy * cx) - longint'(uc) * cy, FRAC), 44);
		ab = a2 * b2;
		// a^2 b^2 carries 4*FRAC fraction bits; bring it to Q8
		if (4 * FRAC >= 8)
			ab = asr_round(ab, 4 * FRAC - 8);
		else
			ab = (ab > ((longint'(1) << 62) >>> (8 - 4 * FRAC))) ?
				(longint'(1) << 62) : (ab << (8 - 4 * FRAC));
		f = sat_signed(asr_round(-(dh * cx + eh * cy), FRAC) - ab, 56);
		r.xx = ua[29:0];
		r.xy_half = hxy[29:0];
		r.yy = uc[29:0];
		r.x_half = dh[43:0];
		r.y_half = eh[43:0];
		r.cst = f[55:0];
		return r;
	endfunction

	function automatic ellipse_t random_ellipse();
		ellipse_t e;
		e.semi_major = $urandom_range(0, 3) == 0 ? 15'($urandom_range(0, 15)) : 15'($urandom);
		e.semi_minor = $urandom_range(0, 3) == 0 ? 15'($urandom_range(0, 15)) : 15'($urandom);
		e.centre_x = 16'($urandom);
		e.centre_y = 16'($urandom);
		e.angle = 16'($signed($urandom_range(0, 2 * 25736)) - 25736);
		return e;
	endfunction

	function automatic ellipse_t mk(int a, int b, int cx, int cy, int ang);
		ellipse_t e;
		e.semi_major = 15'(a);
		e.semi_minor = 15'(b);
		e.centre_x = 16'(cx);
		e.centre_y = 16'(cy);
		e.angle = 16'(ang);
		return e;
	endfunction

	// driver: bursts of random length separated by random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ellipse_ch.valid <= 1'b0;
			ellipse_ch.semi_major <= '0;
			ellipse_ch.semi_minor <= '0;
			ellipse_ch.centre_x <= '0;
			ellipse_ch.centre_y <= '0;
			ellipse_ch.angle <= '0;
		end else begin
			if (ellipse_ch.valid && ellipse_ch.ready) begin
				coef_expect_q.push_back(conic_of({ellipse_ch.semi_major, ellipse_ch.semi_minor,
					ellipse_ch.centre_x, ellipse_ch.centre_y, ellipse_ch.angle}));
			end
			if (!ellipse_ch.valid || ellipse_ch.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					ellipse_ch.valid <= 1'b0;
				end else if (pending_q.size() > 0 && !hold_send) begin
					ellipse_t e;
					e = pending_q.pop_front();
					ellipse_ch.valid <= 1'b1;
					{ellipse_ch.semi_major, ellipse_ch.semi_minor, ellipse_ch.centre_x,
						ellipse_ch.centre_y, ellipse_ch.angle} <= e;
					if (burst_left > 0) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(0, 40);
						gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
					end
				end else begin
					ellipse_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern switches mode every so often
	int stall_mode = 0;
	int mode_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conic_ch.ready <= 1'b0;
		end else begin
			if (conic_ch.valid && conic_ch.ready) begin
				if (coef_expect_q.size() == 0) begin
					$error("conic result with no request outstanding");
					n_fail++;
				end else begin
					conic_t x;
					x = coef_expect_q.pop_front();
					if (conic_ch.coef_xx !== x.xx) begin
						$error("coef_xx exp %0d got %0d", x.xx, conic_ch.coef_xx);
						n_fail++;
					end
					if (conic_ch.coef_xy_half !== x.xy_half) begin
						$error("coef_xy_half exp %0d got %0d", x.xy_half, conic_ch.coef_xy_half);
						n_fail++;
					end
					if (conic_ch.coef_yy !== x.yy) begin
						$error("coef_yy exp %0d got %0d", x.yy, conic_ch.coef_yy);
						n_fail++;
					end
					if (conic_ch.coef_x_half !== x.x_half) begin
						$error("coef_x_half exp %0d got %0d", x.x_half, conic_ch.coef_x_half);
						n_fail++;
					end
					if (conic_ch.coef_y_half !== x.y_half) begin
						$error("coef_y_half exp %0d got %0d", x.y_half, conic_ch.coef_y_half);
						n_fail++;
					end
					if (conic_ch.coef_const !== x.cst) begin
						$error("coef_const exp %0d got %0d", x.cst, conic_ch.coef_const);
						n_fail++;
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: conic_ch.ready <= 1'b1;
				1: conic_ch.ready <= ($urandom_range(0, 3) != 0);
				2: conic_ch.ready <= ($urandom_range(0, 3) == 0);
				default: conic_ch.ready <= (cycle_cnt % 7) < 3;
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == MAX_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		// corners: zero and full lengths, centres, angle at both limits and the
		// quarter-turn fold boundaries
		pending_q.push_back(mk(0, 0, 0, 0, 0));
		pending_q.push_back(mk(32767, 32767, 65535, 65535, 0));
		pending_q.push_back(mk(32767, 0, 65535, 65535, 25736));
		pending_q.push_back(mk(0, 32767, 65535, 65535, -25736));
		pending_q.push_back(mk(32767, 32767, 65535, 0, 12868));
		pending_q.push_back(mk(32767, 1, 0, 65535, -12868));
		pending_q.push_back(mk(32767, 100, 65535, 65535, 12869));
		pending_q.push_back(mk(100, 32767, 65535, 65535, -12869));
		pending_q.push_back(mk(32767, 0, 65535, 65535, 6434));
		pending_q.push_back(mk(0, 32767, 65535, 65535, -6434));
		pending_q.push_back(mk(1, 1, 1, 1, 1));
		pending_q.push_back(mk(32767, 32767, 32768, 32768, -1));
		pending_q.push_back(mk(21845, 10922, 43690, 21845, 19302));
		pending_q.push_back(mk(10922, 21845, 21845, 43690, -19302));
		pending_q.push_back(mk(16, 8, 160, 320, 4096));
		pending_q.push_back(mk(32767, 16384, 65535, 65535, 21000));
		// angles past plus or minus pi
		pending_q.push_back(mk(32767, 1000, 65535, 65535, 32767));
		pending_q.push_back(mk(1000, 32767, 65535, 65535, -32768));
		for (int i = 0; i < N_RANDOM / 2; i++)
			pending_q.push_back(random_ellipse());
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_q.size() == 0);
		// drain the pipeline completely before the second half
		hold_send = 1'b1;
		@(posedge clk);
		wait (coef_expect_q.size() == 0 && !ellipse_ch.valid);
		for (int i = 0; i < N_RANDOM / 2; i++)
			pending_q.push_back(random_ellipse());
		hold_send = 1'b0;
		wait (pending_q.size() == 0);
		@(posedge clk);
		wait (!ellipse_ch.valid && coef_expect_q.size() == 0);
		repeat (LATENCY + 5) @(posedge clk);
		if (n_fail == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
